[rtl/core/sps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the servo pulse scheduler
// transaction kinds, sequencer states and fixed sizes of the channel tables
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int NUM_CH  = 8;
	localparam int CH_W    = 3;
	localparam int TICK_W  = 16;
	localparam int LEN_W   = 4;

	localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd20000;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_SET  = 2'd1,
		KIND_SYNC = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_SEARCH = 2'd2,
		ST_RESULT = 2'd3
	} state_t;

endpackage

`default_nettype wire

[rtl/core/servo_pulse_scheduler_unit.sv]
// sequence: a tick, a width write or a rejected sync goes from idle straight to the result
//   state; an accepted sync walks all 8 channels, scanning each one and running a binary
//   search and insert for each enabled channel, then goes to the result state
// input: a new transaction is taken only in idle, once the result state has loaded its result;
//   a sync holds in_ready low for the whole walk through the shared comparator
// reset: arst_n clears levels, counter, tables lengths and widths at once; period = 20000
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_pulse_scheduler_unit: multichannel servo pulse generator
// keeps a width per channel, builds a sorted step table on sync with one
// shared comparator, and raises / clears the channel outputs per frame
// ----------------------------------------------------------------------------
module servo_pulse_scheduler_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	// input transactions
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [1:0]                       kind,
	input  wire  [sps_pkg::CH_W-1:0]         channel,
	input  wire  [sps_pkg::TICK_W-1:0]       width,
	// result transactions
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [sps_pkg::NUM_CH-1:0]       pulse_levels,
	output logic                             sync_rejected,
	output logic [sps_pkg::LEN_W-1:0]        table_entries,
	// period register
	input  wire                              cfg_wr_en,
	input  wire  [sps_pkg::TICK_W-1:0]       cfg_wr_data
);
	import sps_pkg::*;

	// sequencer
	state_t state_q, state_d;

	// configuration and channel widths
	logic [TICK_W-1:0] period_q;
	logic [TICK_W-1:0] chan_w_q [NUM_CH];

	// build table (back bank) and active table
	logic [TICK_W-1:0] work_cmp_q [NUM_CH];
	logic [NUM_CH-1:0] work_msk_q [NUM_CH];
	logic [TICK_W-1:0] act_cmp_q  [NUM_CH];
	logic [NUM_CH-1:0] act_msk_q  [NUM_CH];
	logic [LEN_W-1:0]  pend_len_q;
	logic [LEN_W-1:0]  act_len_q;
	logic              pending_q;

	// frame state
	logic [NUM_CH-1:0] en_mask_q;
	logic [CH_W-1:0]   step_q;
	logic [TICK_W-1:0] cnt_q;
	logic [NUM_CH-1:0] lvl_q;
	logic              rej_q;

	// build walk registers
	logic [CH_W-1:0]   ch_q;
	logic [LEN_W-1:0]  lo_q;
	logic [LEN_W-1:0]  hi_q;

	// result register
	logic              out_valid_q;
	logic [NUM_CH-1:0] pulse_levels_q;
	logic              sync_rejected_q;
	logic [LEN_W-1:0]  table_entries_q;

	// sequencer controls
	logic in_acc;
	logic do_tick;
	logic do_set;
	logic start_sync;
	logic do_reject;
	logic scan_hit;
	logic srch_lt;
	logic srch_gt;
	logic srch_eq;
	logic do_insert;
	logic advance;
	logic finish_build;
	logic load_out;

	// shared comparator path
	logic [TICK_W-1:0] cur_w;
	logic [NUM_CH-1:0] ch_bit;
	logic [LEN_W-1:0]  mid_sum;
	logic [CH_W-1:0]   mid_idx;
	logic [TICK_W-1:0] cmp_mid;
	logic              ch_done;

	// tick path
	logic [TICK_W:0]   cnt_inc;
	logic              wrap;
	logic              swap;
	logic [TICK_W-1:0] cnt_n;
	logic [NUM_CH-1:0] lvl_raise;
	logic [CH_W-1:0]   step_base;
	logic [LEN_W-1:0]  len_eff;
	logic [TICK_W-1:0] cmp_eff;
	logic [NUM_CH-1:0] msk_eff;
	logic              hit;
	logic [LEN_W-1:0]  step_inc;
	logic [NUM_CH-1:0] lvl_n;
	logic [CH_W-1:0]   step_n;

	assign in_ready      = (state_q == ST_IDLE);
	assign in_acc        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign pulse_levels  = pulse_levels_q;
	assign sync_rejected = sync_rejected_q;
	assign table_entries = table_entries_q;

	// one compare per cycle against the midpoint of the search window
	assign cur_w   = chan_w_q[ch_q];
	assign ch_bit  = NUM_CH'(1) << ch_q;
	assign mid_sum = lo_q + hi_q;
	assign mid_idx = mid_sum[LEN_W-1:1];
	assign cmp_mid = work_cmp_q[mid_idx];
	assign ch_done = (ch_q == CH_W'(NUM_CH - 1));

	// frame counter advance; a pending table takes over at the wrap
	always_comb begin
		cnt_inc   = {1'b0, cnt_q} + (TICK_W + 1)'(1);
		wrap      = (cnt_inc >= {1'b0, period_q});
		swap      = wrap && pending_q;
		cnt_n     = wrap ? '0 : cnt_inc[TICK_W-1:0];
		lvl_raise = wrap ? (lvl_q | en_mask_q) : lvl_q;
		step_base = wrap ? '0 : step_q;
		len_eff   = swap ? pend_len_q : act_len_q;
		// after a swap the step is zero, so only the first build entry matters
		cmp_eff   = swap ? work_cmp_q[0] : act_cmp_q[step_base];
		msk_eff   = swap ? work_msk_q[0] : act_msk_q[step_base];
		hit       = (len_eff != '0) && ({1'b0, step_base} < len_eff) && (cnt_n == cmp_eff);
		step_inc  = {1'b0, step_base} + LEN_W'(1);
		lvl_n     = hit ? (lvl_raise & ~msk_eff) : lvl_raise;
		step_n    = (hit && (step_inc < len_eff)) ? step_inc[CH_W-1:0] : step_base;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d      = state_q;
		do_tick      = 1'b0;
		do_set       = 1'b0;
		start_sync   = 1'b0;
		do_reject    = 1'b0;
		scan_hit     = 1'b0;
		srch_lt      = 1'b0;
		srch_gt      = 1'b0;
		srch_eq      = 1'b0;
		do_insert    = 1'b0;
		advance      = 1'b0;
		finish_build = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_RESULT;
					case (kind)
						KIND_TICK: do_tick = 1'b1;
						KIND_SET:  do_set  = 1'b1;
						KIND_SYNC: begin
							if (pending_q) begin
								do_reject = 1'b1;
							end else begin
								start_sync = 1'b1;
								state_d    = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// disabled channels are skipped without a search
				if (cur_w == '0) begin
					advance = 1'b1;
				end else begin
					scan_hit = 1'b1;
					state_d  = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					if (cur_w < cmp_mid) begin
						srch_lt = 1'b1;
					end else if (cur_w > cmp_mid) begin
						srch_gt = 1'b1;
					end else begin
						// equal width joins the existing step
						srch_eq = 1'b1;
						advance = 1'b1;
					end
				end else begin
					do_insert = 1'b1;
					advance   = 1'b1;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (advance) begin
			if (ch_done) begin
				finish_build = 1'b1;
				state_d      = ST_RESULT;
			end else begin
				state_d = ST_SCAN;
			end
		end
	end

	// control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			for (int i = 0; i < NUM_CH; i++) begin
				chan_w_q[i] <= '0;
			end
			pend_len_q  <= '0;
			act_len_q   <= '0;
			pending_q   <= 1'b0;
			en_mask_q   <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			lvl_q       <= '0;
			rej_q       <= 1'b0;
			ch_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				period_q <= cfg_wr_data;
			end
			if (in_acc) begin
				rej_q <= do_reject;
			end
			if (do_set) begin
				chan_w_q[channel] <= width;
			end
			if (do_tick) begin
				cnt_q  <= cnt_n;
				lvl_q  <= lvl_n;
				step_q <= step_n;
				if (swap) begin
					act_len_q <= pend_len_q;
					pending_q <= 1'b0;
				end
			end
			if (start_sync) begin
				pend_len_q <= '0;
				en_mask_q  <= '0;
				ch_q       <= '0;
			end
			if (scan_hit) begin
				en_mask_q <= en_mask_q | ch_bit;
				lo_q      <= '0;
				hi_q      <= pend_len_q;
			end
			if (srch_lt) begin
				hi_q <= {1'b0, mid_idx};
			end
			if (srch_gt) begin
				lo_q <= {1'b0, mid_idx} + LEN_W'(1);
			end
			if (do_insert) begin
				pend_len_q <= pend_len_q + LEN_W'(1);
			end
			if (advance) begin
				ch_q <= ch_q + CH_W'(1);
			end
			if (finish_build) begin
				pending_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// step tables, written only by the build walk and the frame swap
	always_ff @(posedge clk) begin
		if (srch_eq) begin
			work_msk_q[mid_idx] <= work_msk_q[mid_idx] | ch_bit;
		end
		if (do_insert) begin
			// open a slot at lo by moving the tail up one place
			for (int k = 1; k < NUM_CH; k++) begin
				if ((LEN_W'(k) > lo_q) && (LEN_W'(k) <= pend_len_q)) begin
					work_cmp_q[k] <= work_cmp_q[k-1];
					work_msk_q[k] <= work_msk_q[k-1];
				end
			end
			work_cmp_q[lo_q[CH_W-1:0]] <= cur_w;
			work_msk_q[lo_q[CH_W-1:0]] <= ch_bit;
		end
		if (do_tick && swap) begin
			for (int k = 0; k < NUM_CH; k++) begin
				act_cmp_q[k] <= work_cmp_q[k];
				act_msk_q[k] <= work_msk_q[k];
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			pulse_levels_q  <= lvl_q;
			sync_rejected_q <= rej_q;
			table_entries_q <= act_len_q;
		end
	end

endmodule

`default_nettype wire

[rtl/core/sps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sps_checker: port level checks of the servo pulse scheduler
// watches transactions on both channels and the result fields over time
// ----------------------------------------------------------------------------
module sps_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire [1:0]                  kind,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [sps_pkg::NUM_CH-1:0]  pulse_levels,
	input wire                        sync_rejected,
	input wire [sps_pkg::LEN_W-1:0]   table_entries
);
	import sps_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] open_q;
	logic [1:0] last_kind_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= '0;
			last_kind_q <= '0;
		end else begin
			open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (in_acc) begin
				last_kind_q <= kind;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable(pulse_levels) && $stable(sync_rejected) && $stable(table_entries))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (open_q != 2'd0) && (open_q != 2'd3))
		else $error("result without a matching input transaction");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready right after an accepted transaction");

	a_entries: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> table_entries <= LEN_W'(NUM_CH))
		else $error("table holds more steps than channels");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sync_rejected && (open_q == 2'd1) |-> last_kind_q == KIND_SYNC)
		else $error("rejection reported for a non-sync transaction");

endmodule

bind servo_pulse_scheduler_unit sps_checker u_sps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.kind          (kind),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.pulse_levels  (pulse_levels),
	.sync_rejected (sync_rejected),
	.table_entries (table_entries)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for servo_pulse_scheduler_unit
// feeds tick, width and sync transactions through the valid/ready input,
// predicts levels, sync rejects and table size per transaction and checks
// every result in order, across several frame periods and random stalls
// ----------------------------------------------------------------------------
module tb;
	import sps_pkg::*;

	// kind code left unused by the block, must change nothing
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 92;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CH_W-1:0]   channel;
		logic [TICK_W-1:0] width;
	} servo_cmd_t;

	typedef struct packed {
		logic [NUM_CH-1:0] levels;
		logic              rejected;
		logic [LEN_W-1:0]  entries;
	} servo_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        in_kind = '0;
	logic [CH_W-1:0]   in_channel = '0;
	logic [TICK_W-1:0] in_width = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [NUM_CH-1:0] pulse_levels;
	logic              sync_rejected;
	logic [LEN_W-1:0]  table_entries;
	logic              cfg_wr_en = 1'b0;
	logic [TICK_W-1:0] cfg_wr_data = '0;

	// stimulus and scoreboard
	servo_cmd_t    cmd_q [$];
	servo_result_t expected_q [$];
	servo_cmd_t    drv_cmd;
	servo_result_t exp_res;
	logic [TICK_W-1:0] plan_width [NUM_CH] = '{default: '0};
	logic          in_taken = 1'b0;
	logic          idle_on = 1'b0;
	logic          hold_req = 1'b0;
	int            hold_left = 0;
	int            send_idle = 0;
	int            recv_idle = 0;
	int            fail_count = 0;
	int            result_count = 0;
	int            push_count = 0;
	int            cycle_count = 0;

	// predictor state, mirrors the block
	logic [TICK_W-1:0] mdl_period = PERIOD_RESET;
	logic [TICK_W-1:0] chan_width [NUM_CH] = '{default: '0};
	logic [TICK_W-1:0] step_cmp [2][NUM_CH] = '{default: '0};
	logic [NUM_CH-1:0] step_clr [2][NUM_CH] = '{default: '0};
	int                bank_len [2] = '{0, 0};
	logic              act_bank = 1'b0;
	logic              table_pend = 1'b0;
	logic [NUM_CH-1:0] en_mask = '0;
	logic [NUM_CH-1:0] level_reg = '0;
	logic [TICK_W-1:0] frame_cnt = '0;
	int                cur_step = 0;

	servo_pulse_scheduler_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (in_kind),
		.channel       (in_channel),
		.width         (in_width),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pulse_levels  (pulse_levels),
		.sync_rejected (sync_rejected),
		.table_entries (table_entries),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// applies one transaction to the predictor state and returns its result
	function automatic servo_result_t predict_servo_outputs(servo_cmd_t cmd);
		servo_result_t     res;
		logic              back;
		logic [NUM_CH-1:0] en;
		int                len, lo, hi, mid, nxt;
		bit                found;
		res.rejected = 1'b0;
		case (cmd.kind)
		KIND_TICK: begin
			nxt = int'(frame_cnt) + 1;
			// frame start: raise enabled outputs, swap in a pending table
			if (nxt >= int'(mdl_period)) begin
				nxt = 0;
				level_reg |= en_mask;
				if (table_pend) begin
					act_bank = ~act_bank;
					table_pend = 1'b0;
				end
				cur_step = 0;
			end
			frame_cnt = TICK_W'(nxt);
			len = bank_len[act_bank];
			// compare hit clears this step's channels and moves to the next step
			if (len > 0 && cur_step < len && cur_step < NUM_CH &&
			    frame_cnt == step_cmp[act_bank][cur_step]) begin
				level_reg &= ~step_clr[act_bank][cur_step];
				if (cur_step + 1 < len)
					cur_step++;
			end
		end
		KIND_SET: chan_width[cmd.channel] = cmd.width;
		KIND_SYNC: begin
			if (table_pend) begin
				res.rejected = 1'b1;
			end else begin
				back = ~act_bank;
				len = 0;
				en = '0;
				for (int i = 0; i < NUM_CH; i++) begin
					if (chan_width[i] != '0) begin
						en[i] = 1'b1;
						lo = 0;
						hi = len;
						found = 1'b0;
						// binary search, equal widths merge into one step
						while (lo < hi && !found) begin
							mid = (lo + hi) / 2;
							if (chan_width[i] < step_cmp[back][mid])
								hi = mid;
							else if (chan_width[i] > step_cmp[back][mid])
								lo = mid + 1;
							else begin
								step_clr[back][mid][i] = 1'b1;
								found = 1'b1;
							end
						end
						if (!found) begin
							for (int k = len; k > lo; k--) begin
								step_cmp[back][k] = step_cmp[back][k-1];
								step_clr[back][k] = step_clr[back][k-1];
							end
							step_cmp[back][lo] = chan_width[i];
							step_clr[back][lo] = NUM_CH'(1) << i;
							len++;
						end
					end
				end
				en_mask = en;
				bank_len[back] = len;
				table_pend = 1'b1;
			end
		end
		default: ;
		endcase
		res.levels = level_reg;
		res.entries = LEN_W'(bank_len[act_bank]);
		return res;
	endfunction

	task automatic push_cmd(logic [1:0] k, logic [CH_W-1:0] c, logic [TICK_W-1:0] w);
		cmd_q.push_back('{kind: k, channel: c, width: w});
		push_count++;
		if (k == KIND_SET)
			plan_width[c] = w;
	endtask

	// random mix of ticks, width updates, syncs and a little noise
	task automatic queue_random(int n, int cap);
		int                r;
		logic [CH_W-1:0]   c;
		logic [TICK_W-1:0] w;
		repeat (n) begin
			r = $urandom_range(0, 99);
			c = CH_W'($urandom_range(0, NUM_CH - 1));
			w = TICK_W'($urandom);
			if (r < 58) begin
				push_cmd(KIND_TICK, c, w);
			end else if (r < 84) begin
				case ($urandom_range(0, 9))
				0: w = '0;
				1: w = TICK_W'($urandom);
				2: w = plan_width[CH_W'($urandom_range(0, NUM_CH - 1))];
				default: w = TICK_W'($urandom_range(1, cap + 2));
				endcase
				push_cmd(KIND_SET, c, w);
			end else if (r < 95) begin
				push_cmd(KIND_SYNC, c, w);
			end else begin
				push_cmd(KIND_UNUSED, c, w);
			end
		end
	endtask

	// only called while nothing is in flight
	task automatic write_period(logic [TICK_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mdl_period = v;
	endtask

	// every queued transaction has been answered
	task automatic wait_idle();
		while (cmd_q.size() != 0 || result_count < push_count)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// input driver: next transaction once the current one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (send_idle > 0) begin
					send_idle <= send_idle - 1;
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 5) == 0) begin
					send_idle <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					drv_cmd = cmd_q.pop_front();
					in_kind <= drv_cmd.kind;
					in_channel <= drv_cmd.channel;
					in_width <= drv_cmd.width;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold, counted here so the block backs up into its input
	always @(posedge clk) begin
		if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result side stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (recv_idle > 0) begin
				recv_idle <= recv_idle - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				recv_idle <= $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: check results first, then predict the transaction taken now
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %0d: levels %h rejected %b entries %0d",
							result_count, pulse_levels, sync_rejected, table_entries);
					fail_count++;
				end else begin
					exp_res = expected_q.pop_front();
					if (exp_res.levels !== pulse_levels || exp_res.rejected !== sync_rejected ||
					    exp_res.entries !== table_entries) begin
						if (fail_count < 10)
							$display("mismatch at result %0d: exp %h %b %0d got %h %b %0d",
								result_count, exp_res.levels, exp_res.rejected,
								exp_res.entries, pulse_levels, sync_rejected,
								table_entries);
						fail_count++;
					end
				end
				result_count++;
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_servo_outputs({in_kind, in_channel, in_width}));
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int per;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short frame so the directed part wraps several times
		write_period(16'd5);
		idle_on = 1'b1;
		push_cmd(KIND_TICK, 3'd0, 16'h0000);       // outputs still low before the first wrap
		push_cmd(KIND_UNUSED, 3'd7, 16'hFFFF);     // unused kind changes nothing
		push_cmd(KIND_SYNC, 3'd0, 16'h0000);       // empty table
		push_cmd(KIND_SYNC, 3'd7, 16'hFFFF);       // sync while pending is rejected
		repeat (5) push_cmd(KIND_TICK, CH_W'($urandom), TICK_W'($urandom));
		push_cmd(KIND_SET, 3'd0, 16'd1);
		push_cmd(KIND_SET, 3'd7, 16'hFFFF);        // beyond the period, stays high
		push_cmd(KIND_SET, 3'd3, 16'd3);
		push_cmd(KIND_SET, 3'd5, 16'd3);           // equal widths share one step
		push_cmd(KIND_SET, 3'd2, 16'd2);
		push_cmd(KIND_SET, 3'd6, 16'd5);           // width equal to the period
		push_cmd(KIND_SYNC, 3'd1, 16'h5555);
		push_cmd(KIND_SYNC, 3'd6, 16'hAAAA);
		repeat (10) push_cmd(KIND_TICK, CH_W'($urandom), TICK_W'($urandom));
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
			0: per = 1;
			1: per = 0;                             // every tick starts a frame
			2: per = 65535;
			3: per = $urandom_range(2, 8);          // counter left above the new period
			4: per = $urandom_range(9, 24);
			5: per = $urandom_range(2, 24);
			6: per = $urandom_range(25, 60);
			7: per = PERIOD_RESET;
			default: per = $urandom_range(2, 16);
			endcase
			// last phase runs with no idling on either side
			if (ph == 9)
				idle_on = 1'b0;
			write_period(TICK_W'(per));
			if (ph == 5) begin
				queue_random(PHASE_ITEMS / 2, per);
				@(negedge clk);
				hold_req = 1'b1;
				@(negedge clk);
				hold_req = 1'b0;
				// sender pauses here until every result is back
				wait_idle();
				queue_random(PHASE_ITEMS / 2, per);
			end else begin
				queue_random(PHASE_ITEMS, per);
			end
			wait_idle();
		end

		repeat (20) @(negedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/core/sps_pkg.sv
rtl/core/servo_pulse_scheduler_unit.sv
rtl/core/sps_checker.sv
sim/tb.sv
